>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/core/dlcr_pkg.sv
package dlcr_pkg;

    // default reply queue depth
    localparam int REPLY_QUEUE_DEPTH_DEF = 16;

    // record lengths
    localparam int SENSOR_LEN = 7;
    localparam int SPEED_LEN  = 5;
    localparam int DRIVE_LEN  = 3;

    // byte codes
    localparam logic [7:0] EMPTY_REPLY      = 8'd255;
    localparam logic [7:0] CMD_SPEED        = 8'd1;
    localparam logic [7:0] SPI_SENSOR_START = 8'd255;
    localparam logic [7:0] SPI_DRIVE_START  = 8'd254;
    localparam logic [7:0] UART_SENSOR_REQ  = 8'd87;
    localparam logic [7:0] UART_DRIVE_REQ   = 8'd89;
    localparam logic [7:0] UART_MAP_REQ     = 8'd69;

    // source link codes
    localparam logic CH_SPI  = 1'b0;
    localparam logic CH_UART = 1'b1;

    // record types and reset contents
    typedef logic [7:0] sensor_arr_t [SENSOR_LEN];
    typedef logic [7:0] speed_arr_t  [SPEED_LEN];
    typedef logic [7:0] drive_arr_t  [DRIVE_LEN];

    localparam sensor_arr_t SENSOR_INIT = '{8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2};
    localparam speed_arr_t  SPEED_INIT  = '{8'd0, 8'd0, 8'd1, 8'd1, 8'd0};
    localparam drive_arr_t  DRIVE_INIT  = '{8'd10, 8'd10, 8'd1};

    // spi frame state
    typedef enum logic [2:0] {
        SPI_IDLE   = 3'b001,
        SPI_SENSOR = 3'b010,
        SPI_DRIVE  = 3'b100
    } spi_mode_t;

    // micro-operations
    typedef enum logic [3:0] {
        ACT_NOP        = 4'd0,
        ACT_FETCH      = 4'd1,
        ACT_DISPATCH   = 4'd2,
        ACT_SPI_FRAME  = 4'd3,
        ACT_PUSH       = 4'd4,
        ACT_POP_OUT    = 4'd5,
        ACT_UART_LOAD  = 4'd6,
        ACT_UART_START = 4'd7,
        ACT_EMIT       = 4'd8
    } act_t;

    // transmit burst source
    typedef enum logic [1:0] {
        SRC_SENSOR = 2'd0,
        SRC_DRIVE  = 2'd1,
        SRC_MAP    = 2'd2
    } src_t;

    typedef logic [3:0] uaddr_t;

    // microprogram addresses
    localparam uaddr_t UA_FETCH       = 4'd0;
    localparam uaddr_t UA_DISPATCH    = 4'd1;
    localparam uaddr_t UA_SPI_FRAME   = 4'd2;
    localparam uaddr_t UA_PUSH        = 4'd3;
    localparam uaddr_t UA_POP_RD      = 4'd4;
    localparam uaddr_t UA_POP_OUT     = 4'd5;
    localparam uaddr_t UA_UART_LOAD   = 4'd6;
    localparam uaddr_t UA_UART_START  = 4'd7;
    localparam uaddr_t UA_EMIT_SENSOR = 4'd8;
    localparam uaddr_t UA_EMIT_DRIVE  = 4'd9;
    localparam uaddr_t UA_EMIT_MAP    = 4'd10;

    // control word: loop repeats the step until the index reaches its limit,
    // wait_out holds the step while the output register is occupied
    typedef struct packed {
        act_t   act;
        src_t   src;
        logic   loop;
        logic   wait_out;
        uaddr_t nxt;
    } ucw_t;

    // queue control and status between sequencer and queue
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // microprogram rom
    function automatic ucw_t ucode_rom(input uaddr_t addr);
        ucw_t w;
        w = '{act: ACT_NOP, src: SRC_SENSOR, loop: 1'b0, wait_out: 1'b0, nxt: UA_FETCH};
        case (addr)
            UA_FETCH: begin
                w.act = ACT_FETCH;
                w.nxt = UA_DISPATCH;
            end
            UA_DISPATCH: begin
                w.act = ACT_DISPATCH;
            end
            UA_SPI_FRAME: begin
                w.act = ACT_SPI_FRAME;
                w.nxt = UA_POP_RD;
            end
            UA_PUSH: begin
                w.act  = ACT_PUSH;
                w.loop = 1'b1;
                w.nxt  = UA_POP_RD;
            end
            UA_POP_RD: begin
                w.nxt = UA_POP_OUT;
            end
            UA_POP_OUT: begin
                w.act      = ACT_POP_OUT;
                w.wait_out = 1'b1;
            end
            UA_UART_LOAD: begin
                w.act = ACT_UART_LOAD;
            end
            UA_UART_START: begin
                w.act = ACT_UART_START;
            end
            UA_EMIT_SENSOR: begin
                w.act      = ACT_EMIT;
                w.src      = SRC_SENSOR;
                w.loop     = 1'b1;
                w.wait_out = 1'b1;
            end
            UA_EMIT_DRIVE: begin
                w.act      = ACT_EMIT;
                w.src      = SRC_DRIVE;
                w.loop     = 1'b1;
                w.wait_out = 1'b1;
            end
            UA_EMIT_MAP: begin
                w.act      = ACT_EMIT;
                w.src      = SRC_MAP;
                w.loop     = 1'b1;
                w.wait_out = 1'b1;
            end
            default: begin
                w.act = ACT_NOP;
            end
        endcase
        return w;
    endfunction

    // jump table for a fetched byte
    function automatic uaddr_t dispatch(input logic op, input logic [7:0] b,
                                        input spi_mode_t mode, input logic loading);
        uaddr_t t;
        t = UA_FETCH;
        if (op == CH_SPI) begin
            if (mode == SPI_IDLE && b == CMD_SPEED) begin
                t = UA_PUSH;
            end else begin
                t = UA_SPI_FRAME;
            end
        end else if (loading) begin
            t = UA_UART_LOAD;
        end else if (b == CMD_SPEED) begin
            t = UA_UART_START;
        end else if (b == UART_SENSOR_REQ) begin
            t = UA_EMIT_SENSOR;
        end else if (b == UART_DRIVE_REQ) begin
            t = UA_EMIT_DRIVE;
        end else if (b == UART_MAP_REQ) begin
            t = UA_EMIT_MAP;
        end
        return t;
    endfunction

    // last index of a burst
    function automatic logic [2:0] src_last(input src_t src);
        logic [2:0] n;
        case (src)
            SRC_SENSOR: n = 3'(SENSOR_LEN - 1);
            SRC_DRIVE:  n = 3'(DRIVE_LEN - 1);
            default:    n = 3'd2;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/dlcr_queue.sv
module dlcr_queue #(
    parameter int REPLY_QUEUE_DEPTH = dlcr_pkg::REPLY_QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dlcr_pkg::q_ctrl_t ctrl,
    input  logic [7:0]        wr_data,
    output dlcr_pkg::q_stat_t stat,
    output logic [7:0]        rd_data
);

    localparam int QW = $clog2(REPLY_QUEUE_DEPTH);
    localparam int FW = $clog2(REPLY_QUEUE_DEPTH + 1);

    logic [7:0]    q_mem [REPLY_QUEUE_DEPTH];
    logic [QW-1:0] head_reg, head_next;
    logic [QW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    rd_data_reg;

    // status
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FW'(REPLY_QUEUE_DEPTH));
    assign rd_data    = rd_data_reg;

    // pointer and fill update with wrap at the depth
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.push && !stat.full) begin
            tail_next = (tail_reg == QW'(REPLY_QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end else if (ctrl.pop && !stat.empty) begin
            head_next = (head_reg == QW'(REPLY_QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (ctrl.push && !stat.full) begin
            q_mem[tail_reg] <= wr_data;
        end
    end

    // registered read of the head entry
    always_ff @(posedge aclk) begin
        rd_data_reg <= q_mem[head_reg];
    end

endmodule

>>> rtl/core/dual_link_command_relay_unit.sv
// Command relay between an SPI slave link and a UART receiver. Each request
// carries one received byte and its source (s_op 0 SPI, 1 UART). An SPI byte
// drives the frame logic (start byte 1 queues the five speed bytes, 255 opens a
// seven-byte sensor frame, 254 a three-byte drive frame) and always yields one
// reply: the reply queue head, or 255 when the queue is empty; m_queue_dropped
// flags a push onto a full queue. A UART byte either loads the speed record
// (after command 1, five bytes, 87 skipped) or sends a burst: 87 sensor record,
// 89 drive record, 69 the three bytes of the map register (low byte first);
// other UART bytes are ignored. m_last marks the final reply of a request.
// The map register is written over the cfg channel; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Control is a microprogram that runs one step per cycle unless a step waits
// for a request or for the output register: fetch, dispatch, then a UART load
// or start step, SPI frame or queue writes (one queue write per step), queue read
// and reply, or a UART burst with one transmit byte per step; one request at a time.
module dual_link_command_relay_unit #(
    parameter int REPLY_QUEUE_DEPTH = dlcr_pkg::REPLY_QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_channel,
    output logic [7:0]  m_tx_byte,
    output logic        m_last,
    output logic        m_queue_dropped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data
);

    dlcr_pkg::uaddr_t    pc_reg, pc_next;
    dlcr_pkg::ucw_t      ucw;
    logic [2:0]          idx_reg, idx_next;
    logic                advance;
    logic                done;
    logic [2:0]          limit;

    logic                op_reg;
    logic [7:0]          byte_reg;
    logic                dropped_reg;

    dlcr_pkg::spi_mode_t spi_mode_reg;
    logic [2:0]          spi_cnt_reg;
    logic                uart_load_reg;
    logic [2:0]          uart_cnt_reg;
    logic [23:0]         map_reg;

    dlcr_pkg::sensor_arr_t sensor_reg;
    dlcr_pkg::speed_arr_t  speed_reg;
    dlcr_pkg::drive_arr_t  drive_reg;

    logic                m_valid_reg, m_valid_next;
    logic                m_channel_reg;
    logic [7:0]          m_tx_byte_reg;
    logic                m_last_reg;
    logic                m_dropped_reg;
    logic                out_busy;
    logic                out_load;
    logic [7:0]          emit_byte;

    dlcr_pkg::q_ctrl_t   q_ctrl;
    dlcr_pkg::q_stat_t   q_stat;
    logic [7:0]          q_rd_data;

    // reply queue
    dlcr_queue #(
        .REPLY_QUEUE_DEPTH(REPLY_QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (q_ctrl),
        .wr_data (speed_reg[idx_reg]),
        .stat    (q_stat),
        .rd_data (q_rd_data)
    );

    // handshakes
    assign s_ready   = (pc_reg == dlcr_pkg::UA_FETCH);
    assign cfg_ready = 1'b1;
    assign out_busy  = m_valid_reg && !m_ready;

    // sequencer: step advance, loop test and next address
    always_comb begin
        ucw     = dlcr_pkg::ucode_rom(pc_reg);
        advance = 1'b1;
        if (ucw.act == dlcr_pkg::ACT_FETCH) begin
            advance = s_valid;
        end
        if (ucw.wait_out && out_busy) begin
            advance = 1'b0;
        end
        limit = (ucw.act == dlcr_pkg::ACT_PUSH) ? 3'(dlcr_pkg::SPEED_LEN - 1)
                                                : dlcr_pkg::src_last(ucw.src);
        done  = (idx_reg == limit);

        pc_next  = pc_reg;
        idx_next = idx_reg;
        if (advance) begin
            if (ucw.act == dlcr_pkg::ACT_DISPATCH) begin
                pc_next = dlcr_pkg::dispatch(op_reg, byte_reg, spi_mode_reg, uart_load_reg);
            end else if (ucw.loop && !done) begin
                idx_next = idx_reg + 1'b1;
            end else begin
                pc_next  = ucw.nxt;
                idx_next = '0;
            end
        end
    end

    // queue requests
    always_comb begin
        q_ctrl.push = advance && (ucw.act == dlcr_pkg::ACT_PUSH);
        q_ctrl.pop  = advance && (ucw.act == dlcr_pkg::ACT_POP_OUT);
    end

    // burst byte selection
    always_comb begin
        case (ucw.src)
            dlcr_pkg::SRC_SENSOR: emit_byte = sensor_reg[idx_reg];
            dlcr_pkg::SRC_DRIVE:  emit_byte = drive_reg[idx_reg[1:0]];
            default: begin
                case (idx_reg[1:0])
                    2'd0:    emit_byte = map_reg[7:0];
                    2'd1:    emit_byte = map_reg[15:8];
                    default: emit_byte = map_reg[23:16];
                endcase
            end
        endcase
    end

    // output register load
    always_comb begin
        out_load = advance && (ucw.act == dlcr_pkg::ACT_POP_OUT ||
                               ucw.act == dlcr_pkg::ACT_EMIT);
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= dlcr_pkg::UA_FETCH;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
            spi_mode_reg  <= dlcr_pkg::SPI_IDLE;
            spi_cnt_reg   <= '0;
            uart_load_reg <= 1'b0;
            uart_cnt_reg  <= '0;
            dropped_reg   <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;

            // overflow flag per request
            if (ucw.act == dlcr_pkg::ACT_FETCH) begin
                dropped_reg <= 1'b0;
            end else if (q_ctrl.push && q_stat.full) begin
                dropped_reg <= 1'b1;
            end

            // spi frame tracking
            if (ucw.act == dlcr_pkg::ACT_SPI_FRAME) begin
                case (spi_mode_reg)
                    dlcr_pkg::SPI_SENSOR: begin
                        if (spi_cnt_reg == 3'(dlcr_pkg::SENSOR_LEN - 1)) begin
                            spi_cnt_reg  <= '0;
                            spi_mode_reg <= dlcr_pkg::SPI_IDLE;
                        end else begin
                            spi_cnt_reg <= spi_cnt_reg + 1'b1;
                        end
                    end
                    dlcr_pkg::SPI_DRIVE: begin
                        if (spi_cnt_reg == 3'(dlcr_pkg::DRIVE_LEN - 1)) begin
                            spi_cnt_reg  <= '0;
                            spi_mode_reg <= dlcr_pkg::SPI_IDLE;
                        end else begin
                            spi_cnt_reg <= spi_cnt_reg + 1'b1;
                        end
                    end
                    default: begin
                        spi_cnt_reg <= '0;
                        if (byte_reg == dlcr_pkg::SPI_SENSOR_START) begin
                            spi_mode_reg <= dlcr_pkg::SPI_SENSOR;
                        end else if (byte_reg == dlcr_pkg::SPI_DRIVE_START) begin
                            spi_mode_reg <= dlcr_pkg::SPI_DRIVE;
                        end else begin
                            spi_mode_reg <= dlcr_pkg::SPI_IDLE;
                        end
                    end
                endcase
            end

            // uart speed loading
            if (ucw.act == dlcr_pkg::ACT_UART_START) begin
                uart_load_reg <= 1'b1;
                uart_cnt_reg  <= '0;
            end else if (ucw.act == dlcr_pkg::ACT_UART_LOAD &&
                         byte_reg != dlcr_pkg::UART_SENSOR_REQ) begin
                if (uart_cnt_reg == 3'(dlcr_pkg::SPEED_LEN - 1)) begin
                    uart_cnt_reg  <= '0;
                    uart_load_reg <= 1'b0;
                end else begin
                    uart_cnt_reg <= uart_cnt_reg + 1'b1;
                end
            end
        end
    end

    // records and map register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_reg <= dlcr_pkg::SENSOR_INIT;
            speed_reg  <= dlcr_pkg::SPEED_INIT;
            drive_reg  <= dlcr_pkg::DRIVE_INIT;
            map_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                map_reg <= cfg_data;
            end
            if (ucw.act == dlcr_pkg::ACT_SPI_FRAME) begin
                if (spi_mode_reg == dlcr_pkg::SPI_SENSOR) begin
                    sensor_reg[spi_cnt_reg] <= byte_reg;
                end else if (spi_mode_reg == dlcr_pkg::SPI_DRIVE) begin
                    drive_reg[spi_cnt_reg[1:0]] <= byte_reg;
                end
            end
            if (ucw.act == dlcr_pkg::ACT_UART_LOAD &&
                byte_reg != dlcr_pkg::UART_SENSOR_REQ) begin
                speed_reg[uart_cnt_reg] <= byte_reg;
            end
        end
    end

    // request capture and output payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_op;
            byte_reg <= s_rx_byte;
        end
        if (out_load) begin
            if (ucw.act == dlcr_pkg::ACT_POP_OUT) begin
                m_channel_reg <= dlcr_pkg::CH_SPI;
                m_tx_byte_reg <= q_stat.empty ? dlcr_pkg::EMPTY_REPLY : q_rd_data;
                m_last_reg    <= 1'b1;
                m_dropped_reg <= dropped_reg;
            end else begin
                m_channel_reg <= dlcr_pkg::CH_UART;
                m_tx_byte_reg <= emit_byte;
                m_last_reg    <= done;
                m_dropped_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_channel       = m_channel_reg;
    assign m_tx_byte       = m_tx_byte_reg;
    assign m_last          = m_last_reg;
    assign m_queue_dropped = m_dropped_reg;

endmodule

>>> rtl/core/dlcr_checker.sv
`include "assert_macros.svh"

module dlcr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_channel,
    input logic [7:0]  m_tx_byte,
    input logic        m_last,
    input logic        m_queue_dropped
);

    // a stalled reply holds its payload
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_channel) && $stable(m_last), "reply changed while stalled")

    // uart bursts never report queue overflow
    `ASSERT_CLK(a_uart_no_drop, m_valid && m_channel |-> !m_queue_dropped, "overflow flag on uart byte")

    // every spi reply closes its request
    `ASSERT_CLK(a_spi_last, m_valid && !m_channel |-> m_last, "spi reply without last")

    // one request at a time: no acceptance right after an acceptance
    `ASSERT_CLK(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "back-to-back acceptance")

    // reset empties the output register
    `ASSERT_ALWAYS(a_reset_out, !aresetn |=> !m_valid, "reply valid after reset")

endmodule

bind dual_link_command_relay_unit dlcr_checker u_dlcr_checker (.*);

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH      = dlcr_pkg::REPLY_QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_HOLD  = 20;
    localparam int IDLE_PCT    = 18;
    localparam int PHASE_ITEMS = 47;

    // one reply beat as seen on the m_ side
    typedef struct packed {
        logic       channel;
        logic [7:0] tx_byte;
        logic       last;
        logic       dropped;
    } tx_beat_t;

    // directed row: request plus an optional hand-typed spi reply
    typedef struct packed {
        logic       op;
        logic [7:0] rx;
        logic       typed;
        logic [7:0] typed_tx;
        logic       typed_drop;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = 1'b0;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_channel;
    logic [7:0]  m_tx_byte;
    logic        m_last;
    logic        m_queue_dropped;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = 24'd0;

    // predictor state
    dlcr_pkg::spi_mode_t   spi_mode;
    int                    spi_cnt;
    logic                  uart_loading;
    int                    uart_cnt;
    dlcr_pkg::sensor_arr_t sensor_rec;
    dlcr_pkg::speed_arr_t  speed_rec;
    dlcr_pkg::drive_arr_t  drive_rec;
    logic [7:0]            reply_fifo [QDEPTH];
    int                    fifo_head;
    int                    fifo_fill;
    logic [23:0]           map_bits;

    tx_beat_t    pending_tx [$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic        no_idle = 1'b0;

    dual_link_command_relay_unit #(
        .REPLY_QUEUE_DEPTH(QDEPTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_channel      (m_channel),
        .m_tx_byte      (m_tx_byte),
        .m_last         (m_last),
        .m_queue_dropped(m_queue_dropped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // 100 MHz clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // expected replies for one accepted request
    function automatic void relay_predict(input logic op, input logic [7:0] b);
        tx_beat_t   beat;
        logic       drop_flag;
        logic [7:0] burst [$];
        if (op == dlcr_pkg::CH_SPI) begin
            drop_flag = 1'b0;
            case (spi_mode)
                dlcr_pkg::SPI_SENSOR: begin
                    sensor_rec[spi_cnt] = b;
                    spi_cnt++;
                    if (spi_cnt == dlcr_pkg::SENSOR_LEN) begin
                        spi_cnt  = 0;
                        spi_mode = dlcr_pkg::SPI_IDLE;
                    end
                end
                dlcr_pkg::SPI_DRIVE: begin
                    drive_rec[spi_cnt] = b;
                    spi_cnt++;
                    if (spi_cnt == dlcr_pkg::DRIVE_LEN) begin
                        spi_cnt  = 0;
                        spi_mode = dlcr_pkg::SPI_IDLE;
                    end
                end
                default: begin
                    spi_cnt  = 0;
                    spi_mode = dlcr_pkg::SPI_IDLE;
                    if (b == dlcr_pkg::CMD_SPEED) begin
                        for (int k = 0; k < dlcr_pkg::SPEED_LEN; k++) begin
                            if (fifo_fill >= QDEPTH) begin
                                drop_flag = 1'b1;
                            end else begin
                                reply_fifo[(fifo_head + fifo_fill) % QDEPTH] = speed_rec[k];
                                fifo_fill++;
                            end
                        end
                    end else if (b == dlcr_pkg::SPI_SENSOR_START) begin
                        spi_mode = dlcr_pkg::SPI_SENSOR;
                    end else if (b == dlcr_pkg::SPI_DRIVE_START) begin
                        spi_mode = dlcr_pkg::SPI_DRIVE;
                    end
                end
            endcase
            // every spi byte answers with the queue head, or 255 when it is empty
            beat.channel = dlcr_pkg::CH_SPI;
            beat.last    = 1'b1;
            beat.dropped = drop_flag;
            if (fifo_fill == 0) begin
                beat.tx_byte = dlcr_pkg::EMPTY_REPLY;
            end else begin
                beat.tx_byte = reply_fifo[fifo_head];
                fifo_head    = (fifo_head + 1) % QDEPTH;
                fifo_fill--;
            end
            pending_tx.push_back(beat);
        end else if (uart_loading) begin
            // sensor request byte is skipped while loading speed
            if (b != dlcr_pkg::UART_SENSOR_REQ) begin
                speed_rec[uart_cnt] = b;
                uart_cnt++;
                if (uart_cnt == dlcr_pkg::SPEED_LEN) begin
                    uart_cnt     = 0;
                    uart_loading = 1'b0;
                end
            end
        end else begin
            if (b == dlcr_pkg::CMD_SPEED) begin
                uart_loading = 1'b1;
                uart_cnt     = 0;
            end else if (b == dlcr_pkg::UART_SENSOR_REQ) begin
                for (int k = 0; k < dlcr_pkg::SENSOR_LEN; k++) burst.push_back(sensor_rec[k]);
            end else if (b == dlcr_pkg::UART_DRIVE_REQ) begin
                for (int k = 0; k < dlcr_pkg::DRIVE_LEN; k++) burst.push_back(drive_rec[k]);
            end else if (b == dlcr_pkg::UART_MAP_REQ) begin
                burst.push_back(map_bits[7:0]);
                burst.push_back(map_bits[15:8]);
                burst.push_back(map_bits[23:16]);
            end
            // uart burst, last flag on the final byte
            for (int k = 0; k < burst.size(); k++) begin
                beat.channel = dlcr_pkg::CH_UART;
                beat.tx_byte = burst[k];
                beat.last    = (k == burst.size() - 1);
                beat.dropped = 1'b0;
                pending_tx.push_back(beat);
            end
        end
    endfunction

    // one request on the s_ side, called and returning at a falling edge
    task automatic send_request(input logic op, input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        relay_predict(op, b);
        @(negedge aclk);
    endtask

    // map register write, only while the block is idle
    task automatic write_map(input logic [23:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        map_bits = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait for all replies, then let silent requests finish
    task automatic wait_drained();
        while (pending_tx.size() != 0) @(posedge aclk);
        repeat (DRAIN_HOLD) @(posedge aclk);
        @(negedge aclk);
    endtask

    // reply side back-pressure
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // reply checker
    always @(posedge aclk) begin
        tx_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tx.size() == 0) begin
                report_error($sformatf("unexpected reply ch %0d byte %0d",
                                       m_channel, m_tx_byte));
            end else begin
                exp_beat = pending_tx.pop_front();
                if (m_channel !== exp_beat.channel)
                    report_error($sformatf("channel got %0d expected %0d",
                                           m_channel, exp_beat.channel));
                if (m_tx_byte !== exp_beat.tx_byte)
                    report_error($sformatf("tx_byte got %0d expected %0d",
                                           m_tx_byte, exp_beat.tx_byte));
                if (m_last !== exp_beat.last)
                    report_error($sformatf("last got %0d expected %0d",
                                           m_last, exp_beat.last));
                if (m_queue_dropped !== exp_beat.dropped)
                    report_error($sformatf("queue_dropped got %0d expected %0d",
                                           m_queue_dropped, exp_beat.dropped));
            end
        end
    end

    // directed requests: empty queue replies and the final overflow reply are typed in
    stim_row_t directed_rows [29] = '{
        '{dlcr_pkg::CH_SPI,  8'd0,                       1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_UART, dlcr_pkg::UART_SENSOR_REQ,  1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, dlcr_pkg::UART_MAP_REQ,     1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  dlcr_pkg::CMD_SPEED,        1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  dlcr_pkg::SPI_SENSOR_START, 1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  8'h00,                      1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  8'hFF,                      1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  8'h80,                      1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  8'h01,                      1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_SPI,  8'hFE,                      1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_SPI,  8'h45,                      1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_SPI,  8'h7F,                      1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_SPI,  dlcr_pkg::SPI_DRIVE_START,  1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_SPI,  8'hFF,                      1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_SPI,  8'h00,                      1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_SPI,  8'h59,                      1'b1, dlcr_pkg::EMPTY_REPLY, 1'b0},
        '{dlcr_pkg::CH_UART, dlcr_pkg::UART_DRIVE_REQ,   1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, dlcr_pkg::UART_SENSOR_REQ,  1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, dlcr_pkg::CMD_SPEED,        1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, dlcr_pkg::UART_SENSOR_REQ,  1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, 8'h00,                      1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, 8'hFF,                      1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, 8'h01,                      1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, 8'h80,                      1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_UART, 8'h7E,                      1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  dlcr_pkg::CMD_SPEED,        1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  dlcr_pkg::CMD_SPEED,        1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  dlcr_pkg::CMD_SPEED,        1'b0, 8'd0,                  1'b0},
        '{dlcr_pkg::CH_SPI,  dlcr_pkg::CMD_SPEED,        1'b1, 8'h80,                 1'b1}
    };

    // main stimulus
    initial begin
        int         n_items;
        int         pick;
        int         cnt;
        logic [7:0] v;
        logic [7:0] burst_codes [3];
        logic [23:0] map_vals [3];

        burst_codes = '{dlcr_pkg::UART_SENSOR_REQ, dlcr_pkg::UART_DRIVE_REQ,
                        dlcr_pkg::UART_MAP_REQ};
        map_vals    = '{24'h000000, 24'hFFFFFF, 24'($urandom)};

        // predictor state after reset
        spi_mode     = dlcr_pkg::SPI_IDLE;
        spi_cnt      = 0;
        uart_loading = 1'b0;
        uart_cnt     = 0;
        sensor_rec   = dlcr_pkg::SENSOR_INIT;
        speed_rec    = dlcr_pkg::SPEED_INIT;
        drive_rec    = dlcr_pkg::DRIVE_INIT;
        fifo_head    = 0;
        fifo_fill    = 0;
        map_bits     = 24'd0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_map(24'hC35A81);

        // directed part
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].rx);
            if (directed_rows[i].typed)
                pending_tx[$] = '{dlcr_pkg::CH_SPI, directed_rows[i].typed_tx, 1'b1,
                                  directed_rows[i].typed_drop};
        end

        // random phases, one map setting each; middle phase runs without idling
        for (int phase = 0; phase < 3; phase++) begin
            s_valid <= 1'b0;
            wait_drained();
            no_idle = (phase == 1);
            write_map(map_vals[phase]);
            n_items = 0;
            while (n_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0, 1: begin
                        send_request(dlcr_pkg::CH_SPI, dlcr_pkg::CMD_SPEED);
                        n_items += 1;
                    end
                    2: begin
                        send_request(dlcr_pkg::CH_SPI, dlcr_pkg::SPI_SENSOR_START);
                        for (int k = 0; k < dlcr_pkg::SENSOR_LEN; k++)
                            send_request(dlcr_pkg::CH_SPI, 8'($urandom_range(0, 255)));
                        n_items += dlcr_pkg::SENSOR_LEN + 1;
                    end
                    3: begin
                        send_request(dlcr_pkg::CH_SPI, dlcr_pkg::SPI_DRIVE_START);
                        for (int k = 0; k < dlcr_pkg::DRIVE_LEN; k++)
                            send_request(dlcr_pkg::CH_SPI, 8'($urandom_range(0, 255)));
                        n_items += dlcr_pkg::DRIVE_LEN + 1;
                    end
                    4: begin
                        cnt = $urandom_range(1, 3);
                        for (int k = 0; k < cnt; k++)
                            send_request(dlcr_pkg::CH_SPI, 8'($urandom_range(0, 255)));
                        n_items += cnt;
                    end
                    5: begin
                        // speed load with skipped sensor requests mixed in
                        send_request(dlcr_pkg::CH_UART, dlcr_pkg::CMD_SPEED);
                        for (int k = 0; k < dlcr_pkg::SPEED_LEN; k++) begin
                            if ($urandom_range(0, 3) == 0)
                                send_request(dlcr_pkg::CH_UART, dlcr_pkg::UART_SENSOR_REQ);
                            do v = 8'($urandom_range(0, 255));
                            while (v == dlcr_pkg::UART_SENSOR_REQ);
                            send_request(dlcr_pkg::CH_UART, v);
                        end
                        n_items += dlcr_pkg::SPEED_LEN + 1;
                    end
                    6, 7: begin
                        send_request(dlcr_pkg::CH_UART, burst_codes[$urandom_range(0, 2)]);
                        n_items += 1;
                    end
                    default: begin
                        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                        n_items += 1;
                    end
                endcase
            end
        end

        s_valid <= 1'b0;
        no_idle = 1'b0;
        wait_drained();
        if (pending_tx.size() != 0)
            report_error($sformatf("%0d replies never arrived", pending_tx.size()));
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/dlcr_pkg.sv
rtl/core/dlcr_queue.sv
rtl/core/dual_link_command_relay_unit.sv
rtl/core/dlcr_checker.sv
test/tb_top.sv
